### rtl/hcp_pkg.sv
package hcp_pkg;

    // Dimension limit: a stored width or depth is clamped to 2**DIM_BITS.
    localparam int DIM_BITS = 16;
    localparam int GRID_W   = DIM_BITS + 1;

    // Front-to-back queue depth.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Result beat packing: field_value, column, row, height, lowest, highest, error_code.
    localparam int OUT_W = 168;

    localparam logic [3:0] EV_WIDTH  = 4'd0;
    localparam logic [3:0] EV_DEPTH  = 4'd1;
    localparam logic [3:0] EV_SIZE   = 4'd2;
    localparam logic [3:0] EV_SCALE  = 4'd3;
    localparam logic [3:0] EV_RADIUS = 4'd4;
    localparam logic [3:0] EV_MODE   = 4'd5;
    localparam logic [3:0] EV_AHDR   = 4'd6;
    localparam logic [3:0] EV_SAMPLE = 4'd7;
    localparam logic [3:0] EV_END    = 4'd8;
    localparam logic [3:0] EV_ERROR  = 4'd9;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SIG      = 3'd1;
    localparam logic [2:0] ERR_UNEQUAL  = 3'd2;
    localparam logic [2:0] ERR_NOTPOS   = 3'd3;
    localparam logic [2:0] ERR_NODIM    = 3'd4;
    localparam logic [2:0] ERR_MARKER   = 3'd5;
    localparam logic [2:0] ERR_TRUNC    = 3'd6;

    // Chunk markers, first byte in the low bits.
    localparam logic [31:0] TAG_XPTS = 32'h5354_5058;
    localparam logic [31:0] TAG_YPTS = 32'h5354_5059;
    localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
    localparam logic [31:0] TAG_SCAL = 32'h4C41_4353;
    localparam logic [31:0] TAG_CRAD = 32'h4441_5243;
    localparam logic [31:0] TAG_CRVM = 32'h4D56_5243;
    localparam logic [31:0] TAG_ALTW = 32'h5754_4C41;
    localparam logic [31:0] TAG_EOF  = 32'h2046_4F45;

    localparam logic signed [32:0] MIN_RESET = 33'sh0_FFFF_FFFF;
    localparam logic signed [32:0] MAX_RESET = 33'sh1_0000_0000;

    // One classified item handed from front to back.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] fv;
        logic [15:0] col;
        logic [15:0] row;
        logic [2:0]  err;
        logic [15:0] sample;
        logic [15:0] scale;
        logic [15:0] base;
    } rec_t;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h54;
            4'd1:    r = 8'h45;
            4'd2:    r = 8'h52;
            4'd3:    r = 8'h52;
            4'd4:    r = 8'h41;
            4'd5:    r = 8'h47;
            4'd6:    r = 8'h45;
            4'd7:    r = 8'h4E;
            4'd8:    r = 8'h54;
            4'd9:    r = 8'h45;
            4'd10:   r = 8'h52;
            4'd11:   r = 8'h52;
            4'd12:   r = 8'h41;
            4'd13:   r = 8'h49;
            4'd14:   r = 8'h4E;
            default: r = 8'h20;
        endcase
        return r;
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    // IEEE equality: NaN never equal, +0 equals -0.
    function automatic logic f_equal(input logic [31:0] a, input logic [31:0] b);
        logic r;
        if (is_nan(a) || is_nan(b))
        begin
            r = 1'b0;
        end
        else if ((a[30:0] | b[30:0]) == 31'd0)
        begin
            r = 1'b1;
        end
        else
        begin
            r = (a == b);
        end
        return r;
    endfunction

    function automatic logic [GRID_W-1:0] clamp_dim(input logic [16:0] v);
        logic [16:0] lim;
        lim = 17'(1) << DIM_BITS;
        return (v > lim) ? GRID_W'(lim) : GRID_W'(v);
    endfunction

endpackage

### rtl/hcp_front.sv
module hcp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              stream_start,
    input  logic              stream_end,
    output logic              push,
    output hcp_pkg::rec_t     push_rec
);

    typedef enum logic [2:0] {
        PH_SIG, PH_MARK, PH_PAY, PH_AHDR, PH_SAMP, PH_PAD, PH_DONE, PH_ERR
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [3:0]                      idx_reg, idx_next;
    logic [31:0]                     marker_reg, marker_next;
    logic [31:0]                     payload_reg, payload_next;
    logic [31:0]                     first_reg, first_next;
    logic [31:0]                     second_reg, second_next;
    logic [hcp_pkg::GRID_W-1:0]      gw_reg, gw_next;
    logic [hcp_pkg::GRID_W-1:0]      gd_reg, gd_next;
    logic [hcp_pkg::DIM_BITS-1:0]    col_reg, col_next;
    logic [hcp_pkg::DIM_BITS-1:0]    row_reg, row_next;
    logic [15:0]                     scale_reg, scale_next;
    logic [15:0]                     base_reg, base_next;
    logic [7:0]                      low_reg, low_next;

    always_comb
    begin
        phase_t                      ph;
        logic [3:0]                  idx;
        logic [hcp_pkg::GRID_W-1:0]  gw;
        logic [hcp_pkg::GRID_W-1:0]  gd;
        logic [31:0]                 mark_new;
        logic [31:0]                 pay_new;
        logic [3:0]                  idx_inc;
        logic                        scal;
        logic [hcp_pkg::GRID_W-1:0]  col_inc;
        logic [hcp_pkg::GRID_W-1:0]  row_inc;

        ph  = phase_reg;
        idx = idx_reg;
        gw  = gw_reg;
        gd  = gd_reg;
        if (accept && stream_start)
        begin
            ph  = PH_SIG;
            idx = '0;
            gw  = '0;
            gd  = '0;
        end

        mark_new = {data_byte, marker_reg[31:8]};
        pay_new  = {data_byte, payload_reg[31:8]};
        idx_inc  = idx + 4'd1;
        scal     = (marker_reg == hcp_pkg::TAG_SCAL);
        col_inc  = {1'b0, col_reg} + hcp_pkg::GRID_W'(1);
        row_inc  = {1'b0, row_reg} + hcp_pkg::GRID_W'(1);

        phase_next   = phase_reg;
        idx_next     = idx_reg;
        gw_next      = gw_reg;
        gd_next      = gd_reg;
        marker_next  = marker_reg;
        payload_next = payload_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        scale_next   = scale_reg;
        base_next    = base_reg;
        low_next     = low_reg;
        push         = 1'b0;
        push_rec     = '0;

        if (accept)
        begin
            phase_next = ph;
            idx_next   = idx;
            gw_next    = gw;
            gd_next    = gd;

            unique case (ph)
                PH_SIG:
                begin
                    if (data_byte != hcp_pkg::sig_byte(idx))
                    begin
                        push          = 1'b1;
                        push_rec.kind = hcp_pkg::EV_ERROR;
                        push_rec.err  = hcp_pkg::ERR_SIG;
                        phase_next    = PH_ERR;
                    end
                    else if (idx == 4'd15)
                    begin
                        idx_next   = '0;
                        phase_next = PH_MARK;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end

                PH_MARK:
                begin
                    marker_next = mark_new;
                    idx_next    = idx_inc;
                    if (idx == 4'd3)
                    begin
                        idx_next = '0;
                        if (mark_new == hcp_pkg::TAG_XPTS || mark_new == hcp_pkg::TAG_YPTS ||
                            mark_new == hcp_pkg::TAG_SIZE || mark_new == hcp_pkg::TAG_SCAL ||
                            mark_new == hcp_pkg::TAG_CRAD || mark_new == hcp_pkg::TAG_CRVM)
                        begin
                            phase_next = PH_PAY;
                        end
                        else if (mark_new == hcp_pkg::TAG_ALTW)
                        begin
                            if (gw == '0 || gd == '0)
                            begin
                                push          = 1'b1;
                                push_rec.kind = hcp_pkg::EV_ERROR;
                                push_rec.err  = hcp_pkg::ERR_NODIM;
                                phase_next    = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_AHDR;
                            end
                        end
                        else if (mark_new == hcp_pkg::TAG_EOF)
                        begin
                            push          = 1'b1;
                            push_rec.kind = hcp_pkg::EV_END;
                            phase_next    = PH_DONE;
                        end
                        else
                        begin
                            push          = 1'b1;
                            push_rec.kind = hcp_pkg::EV_ERROR;
                            push_rec.err  = hcp_pkg::ERR_MARKER;
                            phase_next    = PH_ERR;
                        end
                    end
                end

                PH_PAY:
                begin
                    payload_next = pay_new;
                    idx_next     = idx_inc;
                    if (scal && idx_inc == 4'd4)
                    begin
                        first_next = pay_new;
                    end
                    else if (scal && idx_inc == 4'd8)
                    begin
                        second_next = pay_new;
                    end
                    else if (idx_inc == (scal ? 4'd12 : 4'd4))
                    begin
                        idx_next   = '0;
                        phase_next = PH_MARK;
                        push       = 1'b1;
                        if (scal)
                        begin
                            if (!hcp_pkg::f_equal(second_reg, first_reg) ||
                                !hcp_pkg::f_equal(pay_new, first_reg))
                            begin
                                push_rec.kind = hcp_pkg::EV_ERROR;
                                push_rec.err  = hcp_pkg::ERR_UNEQUAL;
                                phase_next    = PH_ERR;
                            end
                            else if (first_reg[30:0] == 31'd0 || first_reg[31])
                            begin
                                push_rec.kind = hcp_pkg::EV_ERROR;
                                push_rec.err  = hcp_pkg::ERR_NOTPOS;
                                phase_next    = PH_ERR;
                            end
                            else
                            begin
                                push_rec.kind = hcp_pkg::EV_SCALE;
                                push_rec.fv   = first_reg;
                            end
                        end
                        else if (marker_reg == hcp_pkg::TAG_XPTS)
                        begin
                            gw_next       = hcp_pkg::clamp_dim({1'b0, pay_new[15:0]});
                            push_rec.kind = hcp_pkg::EV_WIDTH;
                            push_rec.fv   = 32'(gw_next);
                        end
                        else if (marker_reg == hcp_pkg::TAG_YPTS)
                        begin
                            gd_next       = hcp_pkg::clamp_dim({1'b0, pay_new[15:0]});
                            push_rec.kind = hcp_pkg::EV_DEPTH;
                            push_rec.fv   = 32'(gd_next);
                        end
                        else if (marker_reg == hcp_pkg::TAG_SIZE)
                        begin
                            gw_next       = hcp_pkg::clamp_dim({1'b0, pay_new[15:0]} + 17'd1);
                            gd_next       = gw_next;
                            push_rec.kind = hcp_pkg::EV_SIZE;
                            push_rec.fv   = 32'(gw_next);
                        end
                        else if (marker_reg == hcp_pkg::TAG_CRAD)
                        begin
                            push_rec.kind = hcp_pkg::EV_RADIUS;
                            push_rec.fv   = pay_new;
                        end
                        else
                        begin
                            push_rec.kind = hcp_pkg::EV_MODE;
                            push_rec.fv   = {16'd0, pay_new[15:0]};
                        end
                    end
                end

                PH_AHDR:
                begin
                    payload_next = pay_new;
                    idx_next     = idx_inc;
                    if (idx == 4'd3)
                    begin
                        idx_next      = '0;
                        scale_next    = pay_new[15:0];
                        base_next     = pay_new[31:16];
                        col_next      = '0;
                        row_next      = '0;
                        phase_next    = PH_SAMP;
                        push          = 1'b1;
                        push_rec.kind = hcp_pkg::EV_AHDR;
                        push_rec.fv   = pay_new;
                    end
                end

                PH_SAMP:
                begin
                    if (!idx[0])
                    begin
                        low_next = data_byte;
                        idx_next = 4'd1;
                    end
                    else
                    begin
                        idx_next        = '0;
                        push            = 1'b1;
                        push_rec.kind   = hcp_pkg::EV_SAMPLE;
                        push_rec.col    = 16'(col_reg);
                        push_rec.row    = 16'(row_reg);
                        push_rec.sample = {data_byte, low_reg};
                        push_rec.scale  = scale_reg;
                        push_rec.base   = base_reg;
                        col_next        = col_inc[hcp_pkg::DIM_BITS-1:0];
                        if (col_inc >= gw)
                        begin
                            col_next = '0;
                            row_next = row_inc[hcp_pkg::DIM_BITS-1:0];
                            if (row_inc >= gd)
                            begin
                                row_next   = '0;
                                phase_next = (gw[0] && gd[0]) ? PH_PAD : PH_MARK;
                            end
                        end
                    end
                end

                PH_PAD:
                begin
                    idx_next = idx_inc;
                    if (idx == 4'd1)
                    begin
                        idx_next   = '0;
                        phase_next = PH_MARK;
                    end
                end

                PH_DONE, PH_ERR:
                begin
                end

                default:
                begin
                end
            endcase

            // early end of stream overrides what this byte produced, unless it ended the stream or raised an error
            if (stream_end && phase_next != PH_DONE && phase_next != PH_ERR)
            begin
                push          = 1'b1;
                push_rec      = '0;
                push_rec.kind = hcp_pkg::EV_ERROR;
                push_rec.err  = hcp_pkg::ERR_TRUNC;
                phase_next    = PH_ERR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            idx_reg   <= '0;
            gw_reg    <= '0;
            gd_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            gw_reg    <= gw_next;
            gd_reg    <= gd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        marker_reg  <= marker_next;
        payload_reg <= payload_next;
        first_reg   <= first_next;
        second_reg  <= second_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        scale_reg   <= scale_next;
        base_reg    <= base_next;
        low_reg     <= low_next;
    end

endmodule

### rtl/hcp_queue.sv
module hcp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hcp_pkg::rec_t     push_rec,
    output logic              full,
    input  logic              pop,
    output logic              avail,
    output hcp_pkg::rec_t     pop_rec
);

    hcp_pkg::rec_t            slot_reg [hcp_pkg::Q_DEPTH];
    logic [hcp_pkg::Q_AW-1:0] wr_reg, wr_next;
    logic [hcp_pkg::Q_AW-1:0] rd_reg, rd_next;
    logic [hcp_pkg::Q_AW:0]   cnt_reg, cnt_next;
    logic                     do_push;
    logic                     do_pop;

    assign full    = (cnt_reg == (hcp_pkg::Q_AW+1)'(hcp_pkg::Q_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign pop_rec = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + (hcp_pkg::Q_AW)'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + (hcp_pkg::Q_AW)'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (hcp_pkg::Q_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (hcp_pkg::Q_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_rec;
        end
    end

endmodule

### rtl/hcp_back.sv
module hcp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_avail,
    input  hcp_pkg::rec_t             q_rec,
    output logic                      q_pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [hcp_pkg::OUT_W-1:0] m_axis_tdata,
    output logic [3:0]                m_axis_tuser
);

    // multiply stage
    logic               a_valid_reg, a_valid_next;
    hcp_pkg::rec_t      a_rec_reg;
    logic signed [31:0] a_prod_reg;

    // running extremes of the current altitude chunk
    logic signed [32:0] min_reg, min_next;
    logic signed [32:0] max_reg, max_next;

    // output stage
    logic               o_valid_reg, o_valid_next;
    logic [3:0]         o_kind_reg;
    logic [31:0]        o_fv_reg;
    logic [15:0]        o_col_reg;
    logic [15:0]        o_row_reg;
    logic signed [32:0] o_h_reg, o_h_next;
    logic signed [32:0] o_lo_reg, o_lo_next;
    logic signed [32:0] o_hi_reg, o_hi_next;
    logic [2:0]         o_err_reg;

    logic               o_free;
    logic               a_adv;
    logic               a_free;
    logic signed [32:0] h;

    assign o_free = !o_valid_reg || m_axis_tready;
    assign a_adv  = a_valid_reg && o_free;
    assign a_free = !a_valid_reg || a_adv;
    assign q_pop  = q_avail && a_free;

    assign h = 33'($signed({a_rec_reg.base, 16'h0000})) + 33'(a_prod_reg);

    always_comb
    begin
        a_valid_next = a_free ? q_avail : a_valid_reg;
        o_valid_next = a_adv ? 1'b1 : (m_axis_tready ? 1'b0 : o_valid_reg);
        min_next     = min_reg;
        max_next     = max_reg;
        o_h_next     = '0;
        o_lo_next    = '0;
        o_hi_next    = '0;
        if (a_adv && a_rec_reg.kind == hcp_pkg::EV_AHDR)
        begin
            min_next = hcp_pkg::MIN_RESET;
            max_next = hcp_pkg::MAX_RESET;
        end
        else if (a_adv && a_rec_reg.kind == hcp_pkg::EV_SAMPLE)
        begin
            min_next  = (h < min_reg) ? h : min_reg;
            max_next  = (h > max_reg) ? h : max_reg;
            o_h_next  = h;
            o_lo_next = min_next;
            o_hi_next = max_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            min_reg     <= hcp_pkg::MIN_RESET;
            max_reg     <= hcp_pkg::MAX_RESET;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_rec_reg  <= q_rec;
            a_prod_reg <= $signed(q_rec.scale) * $signed(q_rec.sample);
        end
        if (a_adv)
        begin
            o_kind_reg <= a_rec_reg.kind;
            o_fv_reg   <= a_rec_reg.fv;
            o_col_reg  <= a_rec_reg.col;
            o_row_reg  <= a_rec_reg.row;
            o_err_reg  <= a_rec_reg.err;
            o_h_reg    <= o_h_next;
            o_lo_reg   <= o_lo_next;
            o_hi_reg   <= o_hi_next;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tdata  = {2'b00, o_err_reg, o_hi_reg, o_lo_reg, o_h_reg,
                            o_row_reg, o_col_reg, o_fv_reg};

endmodule

### rtl/heightfield_chunk_parser_top.sv
// Channel   Dir  Group    Beat contents
// input     in   s_axis   tdata[7:0] file byte, tuser stream start, tlast stream end
// result    out  m_axis   tuser event code, tdata packed result fields (see port)
//
// One byte per cycle sustained while the queue has room; a byte with no result is simply absorbed.
// A byte's result beat is registered in the queue, then the multiply stage, then the output register.
// Front parser and back arithmetic are split by a 4-deep queue; the front stalls
// (s_axis_tready low) only when that queue is full.
// The height multiply (16x16 signed) sits alone in its own stage; min/max and
// the base add follow in the output stage.
// rst_n clears the parser to the signature phase and empties queue and pipeline;
// a beat with tuser high restarts the parser on that same byte.
module heightfield_chunk_parser_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // data_byte
    input  logic                      s_axis_tuser,   // stream_start
    input  logic                      s_axis_tlast,   // stream_end
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // field_value[31:0], column[47:32], row[63:48], height_q16[96:64],
    // lowest_q16[129:97], highest_q16[162:130], error_code[165:163], zero pad
    output logic [hcp_pkg::OUT_W-1:0] m_axis_tdata,
    output logic [3:0]                m_axis_tuser    // event_res
);

    logic          accept;
    logic          push;
    hcp_pkg::rec_t push_rec;
    logic          q_full;
    logic          q_avail;
    logic          q_pop;
    hcp_pkg::rec_t q_rec;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // byte decode and chunk sequencing
    hcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_axis_tdata),
        .stream_start (s_axis_tuser),
        .stream_end   (s_axis_tlast),
        .push         (push),
        .push_rec     (push_rec)
    );

    hcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_rec  (q_rec)
    );

    // height arithmetic, running extremes, result register
    hcp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_avail       (q_avail),
        .q_rec         (q_rec),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### rtl/hcp_assert.sv
module hcp_assert (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [hcp_pkg::OUT_W-1:0] m_axis_tdata,
    input logic [3:0]                m_axis_tuser
);

    // result beat held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("result beat changed under stall");

    // error code present exactly on error events
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == hcp_pkg::EV_ERROR) ==
            (m_axis_tdata[165:163] != hcp_pkg::ERR_NONE)))
    else $error("error code and event kind disagree");

    // height fields only on sample beats
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != hcp_pkg::EV_SAMPLE) |-> (m_axis_tdata[162:64] == '0))
    else $error("height fields nonzero on non-sample beat");

    // running extremes bracket the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == hcp_pkg::EV_SAMPLE) |->
            ($signed(m_axis_tdata[129:97]) <= $signed(m_axis_tdata[96:64])) &&
            ($signed(m_axis_tdata[96:64]) <= $signed(m_axis_tdata[162:130])))
    else $error("sample outside running min/max");

endmodule

bind heightfield_chunk_parser_top hcp_assert u_hcp_assert (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
